// ===== hdl/triangle_normal_centroid_bbox_unit_defines.svh =====
// Assertion macros shared by the triangle normal, centroid and box unit.
`ifndef TRIANGLE_NORMAL_CENTROID_BBOX_UNIT_DEFINES_SVH
`define TRIANGLE_NORMAL_CENTROID_BBOX_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define TNCB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define TNCB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/tncb_pkg.sv =====
// Shared types and codes of the triangle normal, centroid and box unit.
package tncb_pkg;

	// Values of the dimensions register.
	localparam logic [1:0] DIM_SEGMENT  = 2'd2;
	localparam logic [1:0] DIM_TRIANGLE = 2'd3;

	// Pipeline control handed from one section to the next.
	typedef struct packed {
		logic advance;
		logic valid;
	} pipe_ctl_t;

endpackage

// ===== hdl/tncb_cross.sv =====
// Edge vectors and cross product of one element, three pipeline stages.
module tncb_cross
	import tncb_pkg::*;
#(
	parameter int COORD_BITS = 24,
	localparam int EB = COORD_BITS + 1,
	localparam int NB = 2 * EB + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pipe_ctl_t            ctl,
	input  logic                 seg,
	input  logic [9*COORD_BITS-1:0] vtx,
	output logic                 valid,
	output logic signed [NB-1:0] nrm [3]
);

	localparam int PB = 2 * EB;

	logic signed [COORD_BITS-1:0] v [9];
	logic signed [EB-1:0] a_d [3];
	logic signed [EB-1:0] b_d [3];
	logic signed [EB-1:0] a_s1 [3];
	logic signed [EB-1:0] b_s1 [3];
	logic signed [PB-1:0] p_s2 [6];
	logic signed [NB-1:0] n_s3 [3];
	logic v_s1, v_s2, v_s3;

	// A segment is treated as the cross product of (dx, dy, 0) with (0, 0, 1).
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			v[i] = vtx[i*COORD_BITS +: COORD_BITS];
		end
		for (int j = 0; j < 3; j++) begin
			a_d[j] = EB'(v[3+j]) - EB'(v[j]);
			b_d[j] = EB'(v[6+j]) - EB'(v[j]);
		end
		if (seg) begin
			a_d[2] = '0;
			b_d[0] = '0;
			b_d[1] = '0;
			b_d[2] = EB'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			a_s1 <= a_d;
			b_s1 <= b_d;
			p_s2[0] <= PB'(a_s1[1]) * PB'(b_s1[2]);
			p_s2[1] <= PB'(a_s1[2]) * PB'(b_s1[1]);
			p_s2[2] <= PB'(a_s1[2]) * PB'(b_s1[0]);
			p_s2[3] <= PB'(a_s1[0]) * PB'(b_s1[2]);
			p_s2[4] <= PB'(a_s1[0]) * PB'(b_s1[1]);
			p_s2[5] <= PB'(a_s1[1]) * PB'(b_s1[0]);
			for (int j = 0; j < 3; j++) begin
				n_s3[j] <= NB'(p_s2[2*j]) - NB'(p_s2[2*j+1]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (ctl.advance) begin
			v_s1 <= ctl.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign valid = v_s3;
	assign nrm   = n_s3;

endmodule

// ===== hdl/tncb_unitvec.sv =====
// Exact normalization of the normal vector by a pipelined bit-by-bit root search.
module tncb_unitvec
	import tncb_pkg::*;
#(
	parameter int COORD_BITS = 24,
	parameter int NORMAL_FRAC_BITS = 14,
	localparam int NB = 2 * COORD_BITS + 3,
	localparam int OB = NORMAL_FRAC_BITS + 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pipe_ctl_t            ctl,
	input  logic signed [NB-1:0] nrm [3],
	output logic                 valid,
	output logic signed [OB-1:0] unit [3]
);

	localparam int MB  = NB - 1;
	localparam int HB  = MB / 2;
	localparam int TB  = MB - HB;
	localparam int SQB = 2 * MB;
	localparam int SB  = SQB + 2;
	localparam int WB  = SQB + 2 * NORMAL_FRAC_BITS + 6;
	localparam int RS  = NORMAL_FRAC_BITS + 2;

	logic [MB-1:0]    mag [3];
	logic [2*TB-1:0]  hh_s4 [3];
	logic [TB+HB-1:0] hl_s4 [3];
	logic [2*HB-1:0]  ll_s4 [3];
	logic             neg_s4 [3];
	logic             zero_s4;
	logic [SQB-1:0]   sq_s5 [3];
	logic             neg_s5 [3];
	logic             zero_s5;
	logic v_s4, v_s5;

	// Root search state, index 0 is the loaded stage.
	logic [WB-1:0] rem_s [RS+1][3];
	logic [WB-1:0] sm_s  [RS+1][3];
	logic [RS-1:0] m_s   [RS+1][3];
	logic          neg_s [RS+1][3];
	logic [SB-1:0] s_s   [RS+1];
	logic          zero_s [RS+1];
	logic          vld_s [RS+1];

	logic [WB-1:0] delta [RS][3];
	logic          take  [RS][3];
	logic [RS:0]   m_inc [3];
	logic [OB-1:0] lo    [3];
	logic signed [OB-1:0] unit_q [3];
	logic                 valid_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = nrm[i][NB-1] ? MB'(-nrm[i]) : MB'(nrm[i]);
		end
	end

	// The running remainder is n_i^2 * 4^(F+1) - m^2 * s and sm holds s * m,
	// so each candidate bit costs only shifts, one add and one compare.
	always_comb begin
		for (int k = 0; k < RS; k++) begin
			for (int i = 0; i < 3; i++) begin
				delta[k][i] = (sm_s[k][i] << (RS - k)) + (WB'(s_s[k]) << (2 * (RS - 1 - k)));
				take[k][i]  = (delta[k][i] <= rem_s[k][i]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			m_inc[i] = {1'b0, m_s[RS][i]} + (RS+1)'(1);
			lo[i]    = m_inc[i][RS:1];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			zero_s4 <= (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
			for (int i = 0; i < 3; i++) begin
				hh_s4[i]  <= (2*TB)'(mag[i][MB-1:HB]) * (2*TB)'(mag[i][MB-1:HB]);
				hl_s4[i]  <= (TB+HB)'(mag[i][MB-1:HB]) * (TB+HB)'(mag[i][HB-1:0]);
				ll_s4[i]  <= (2*HB)'(mag[i][HB-1:0]) * (2*HB)'(mag[i][HB-1:0]);
				neg_s4[i] <= nrm[i][NB-1];
				sq_s5[i]  <= (SQB'(hh_s4[i]) << (2 * HB)) + (SQB'(hl_s4[i]) << (HB + 1))
					+ SQB'(ll_s4[i]);
				neg_s5[i] <= neg_s4[i];
				rem_s[0][i] <= WB'(sq_s5[i]) << (2 * NORMAL_FRAC_BITS + 2);
				sm_s[0][i]  <= '0;
				m_s[0][i]   <= '0;
				neg_s[0][i] <= neg_s5[i];
			end
			zero_s5   <= zero_s4;
			s_s[0]    <= SB'(sq_s5[0]) + SB'(sq_s5[1]) + SB'(sq_s5[2]);
			zero_s[0] <= zero_s5;
			for (int k = 0; k < RS; k++) begin
				for (int i = 0; i < 3; i++) begin
					rem_s[k+1][i] <= take[k][i] ? rem_s[k][i] - delta[k][i] : rem_s[k][i];
					sm_s[k+1][i]  <= take[k][i] ? sm_s[k][i] + (WB'(s_s[k]) << (RS - 1 - k))
						: sm_s[k][i];
					m_s[k+1][i]   <= m_s[k][i] | (RS'(take[k][i]) << (RS - 1 - k));
					neg_s[k+1][i] <= neg_s[k][i];
				end
				s_s[k+1]    <= s_s[k];
				zero_s[k+1] <= zero_s[k];
			end
			// Half the root rounds to nearest with ties away from zero.
			for (int i = 0; i < 3; i++) begin
				if (zero_s[RS]) begin
					unit_q[i] <= '0;
				end else begin
					unit_q[i] <= neg_s[RS][i] ? OB'(-lo[i]) : lo[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int k = 0; k <= RS; k++) begin
				vld_s[k] <= 1'b0;
			end
			valid_q <= 1'b0;
		end else if (ctl.advance) begin
			v_s4     <= ctl.valid;
			v_s5     <= v_s4;
			vld_s[0] <= v_s5;
			for (int k = 0; k < RS; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
			valid_q <= vld_s[RS];
		end
	end

	assign valid = valid_q;
	assign unit  = unit_q;

endmodule

// ===== hdl/tncb_box_mean.sv =====
// Centroid and bounding box of one element, four pipeline stages.
module tncb_box_mean
	import tncb_pkg::*;
#(
	parameter int COORD_BITS = 24
) (
	input  logic                    clk,
	input  logic                    advance,
	input  logic                    seg,
	input  logic [9*COORD_BITS-1:0] vtx,
	output logic [9*COORD_BITS-1:0] geo
);

	localparam int XB = COORD_BITS + 2;
	localparam int K  = XB + 3;
	localparam int PW = XB + K - 2;
	localparam logic [K-3:0] RECIP = (K-2)'(((64'd1 << K) + 64'd5) / 64'd6);

	logic signed [COORD_BITS-1:0] v [9];
	logic signed [XB-1:0] sum_d [3];
	logic signed [COORD_BITS-1:0] mn_d [3];
	logic signed [COORD_BITS-1:0] mx_d [3];
	logic signed [COORD_BITS-1:0] m01, x01;
	logic [XB-1:0] mag [3];

	logic signed [XB-1:0] sum_s1 [3];
	logic signed [COORD_BITS-1:0] mn_s1 [3], mn_s2 [3], mn_s3 [3];
	logic signed [COORD_BITS-1:0] mx_s1 [3], mx_s2 [3], mx_s3 [3];
	logic [XB-1:0] x_s2 [3], x_s3 [3];
	logic [PW-1:0] prod_s3 [3];
	logic neg_s2 [3], neg_s3 [3];
	logic seg_s1, seg_s2, seg_s3;
	logic [COORD_BITS-1:0] q [3];
	logic [9*COORD_BITS-1:0] geo_s4;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			v[i] = vtx[i*COORD_BITS +: COORD_BITS];
		end
		for (int j = 0; j < 3; j++) begin
			m01 = (v[3+j] < v[j]) ? v[3+j] : v[j];
			x01 = (v[3+j] > v[j]) ? v[3+j] : v[j];
			if (seg) begin
				sum_d[j] = XB'(v[j]) + XB'(v[3+j]);
				mn_d[j]  = m01;
				mx_d[j]  = x01;
			end else begin
				sum_d[j] = XB'(v[j]) + XB'(v[3+j]) + XB'(v[6+j]);
				mn_d[j]  = (v[6+j] < m01) ? v[6+j] : m01;
				mx_d[j]  = (v[6+j] > x01) ? v[6+j] : x01;
			end
		end
		if (seg) begin
			sum_d[2] = '0;
			mn_d[2]  = '0;
			mx_d[2]  = '0;
		end
		for (int j = 0; j < 3; j++) begin
			mag[j] = sum_s1[j][XB-1] ? XB'(-sum_s1[j]) : XB'(sum_s1[j]);
			q[j]   = seg_s3 ? x_s3[j][XB-1:2] : prod_s3[j][PW-1:K];
		end
	end

	// Rounded mean of magnitude m over d vertices is floor((2m + d) / 2d);
	// for three vertices the divide by six is a reciprocal multiply.
	always_ff @(posedge clk) begin
		if (advance) begin
			seg_s1 <= seg;
			seg_s2 <= seg_s1;
			seg_s3 <= seg_s2;
			for (int j = 0; j < 3; j++) begin
				sum_s1[j]  <= sum_d[j];
				mn_s1[j]   <= mn_d[j];
				mx_s1[j]   <= mx_d[j];
				x_s2[j]    <= (mag[j] << 1) + (seg_s1 ? XB'(2) : XB'(3));
				neg_s2[j]  <= sum_s1[j][XB-1];
				mn_s2[j]   <= mn_s1[j];
				mx_s2[j]   <= mx_s1[j];
				prod_s3[j] <= PW'(x_s2[j]) * PW'(RECIP);
				x_s3[j]    <= x_s2[j];
				neg_s3[j]  <= neg_s2[j];
				mn_s3[j]   <= mn_s2[j];
				mx_s3[j]   <= mx_s2[j];
				geo_s4[j*COORD_BITS +: COORD_BITS]     <= neg_s3[j] ? COORD_BITS'(-q[j]) : q[j];
				geo_s4[(3+j)*COORD_BITS +: COORD_BITS] <= mn_s3[j];
				geo_s4[(6+j)*COORD_BITS +: COORD_BITS] <= mx_s3[j];
			end
		end
	end

	assign geo = geo_s4;

endmodule

// ===== hdl/triangle_normal_centroid_bbox_unit.sv =====
// Top level of the triangle normal, centroid and bounding box unit.
// One triangle (or one segment when the dimensions register holds 2) enters per
// clock while the skid register is empty, and one result leaves per clock once the
// pipeline is full and the receiver is ready. The normalization pipeline spends one
// stage on each of the NORMAL_FRAC_BITS + 2 bits of the root search after three
// stages of cross product and three of squaring and summing. The unit normal is
// exact and rounded to nearest, ties away from zero; a degenerate element gives the
// zero vector. Write the dimensions register only while no transaction is in flight.
// There is no start-up sweep: inputs are taken from the first cycle after reset.
`include "triangle_normal_centroid_bbox_unit_defines.svh"

module triangle_normal_centroid_bbox_unit
	import tncb_pkg::*;
#(
	parameter int COORD_BITS = 24,
	parameter int NORMAL_FRAC_BITS = 14,
	localparam int OB    = NORMAL_FRAC_BITS + 2,
	localparam int IN_W  = ((9 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((3 * OB + 9 * COORD_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [1:0]       cfg_wdata,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z from the lowest bit up
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// normal_x, normal_y, normal_z, centroid_x, centroid_y, centroid_z,
	// box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z from the lowest bit up
	output logic [OUT_W-1:0] m_axis_tdata
);

	localparam int NB       = 2 * COORD_BITS + 3;
	localparam int NORM_LAT = NORMAL_FRAC_BITS + 9;
	localparam int MEAN_LAT = 4;
	localparam int DL       = NORM_LAT - MEAN_LAT;
	localparam int GW       = 9 * COORD_BITS;

	logic [1:0] dimensions_q;
	logic       seg;
	logic       adv;
	pipe_ctl_t  ctl_in, ctl_mid;

	logic                 cross_valid;
	logic signed [NB-1:0] nrm [3];
	logic                 norm_valid;
	logic signed [OB-1:0] unit [3];
	logic [GW-1:0]        geo;
	logic [GW-1:0]        geo_dly_q [DL];
	logic [OUT_W-1:0]     pdata;

	logic [OUT_W-1:0] out_q, skid_q;
	logic             out_valid_q, skid_valid_q;

	// Configuration register; codes 0 and 1 behave as triangle mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dimensions_q <= DIM_TRIANGLE;
		end else if (cfg_wen) begin
			dimensions_q <= cfg_wdata;
		end
	end

	assign seg = (dimensions_q == DIM_SEGMENT);

	// The whole pipeline moves together. It halts only when the skid register
	// already holds a result, so one finished result may wait at the output while
	// new transactions keep flowing in.
	assign adv            = !skid_valid_q;
	assign s_axis_tready  = adv;
	assign ctl_in.advance = adv;
	assign ctl_in.valid   = s_axis_tvalid;
	assign ctl_mid.advance = adv;
	assign ctl_mid.valid   = cross_valid;

	tncb_cross #(
		.COORD_BITS(COORD_BITS)
	) u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_in),
		.seg    (seg),
		.vtx    (s_axis_tdata[GW-1:0]),
		.valid  (cross_valid),
		.nrm    (nrm)
	);

	tncb_unitvec #(
		.COORD_BITS(COORD_BITS),
		.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
	) u_unitvec (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_mid),
		.nrm    (nrm),
		.valid  (norm_valid),
		.unit   (unit)
	);

	tncb_box_mean #(
		.COORD_BITS(COORD_BITS)
	) u_box_mean (
		.clk     (clk),
		.advance (adv),
		.seg     (seg),
		.vtx     (s_axis_tdata[GW-1:0]),
		.geo     (geo)
	);

	// The centroid and box finish early; a delay line lines them up with the normal.
	always_ff @(posedge clk) begin
		if (adv) begin
			geo_dly_q[0] <= geo;
			for (int i = 1; i < DL; i++) begin
				geo_dly_q[i] <= geo_dly_q[i-1];
			end
		end
	end

	assign pdata = OUT_W'({geo_dly_q[DL-1], unit[2], unit[1], unit[0]});

	// Output register with a one-entry skid behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= norm_valid;
			end
		end else if (norm_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_axis_tready) begin
			out_q <= skid_valid_q ? skid_q : pdata;
		end else if (adv && norm_valid) begin
			skid_q <= pdata;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	`TNCB_ASSERT_IMPL(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q, "skid holds a result while the output is empty")
	`TNCB_ASSERT_NEXT(a_stall_to_skid, clk, arst_n, out_valid_q && !m_axis_tready && norm_valid && !skid_valid_q, skid_valid_q, "result arriving at a stalled output was not kept")
	`TNCB_ASSERT_IMPL(a_segment_z_zero, clk, arst_n, out_valid_q && seg, (out_q[3*OB-1:2*OB] == '0) && (out_q[3*OB+3*COORD_BITS-1:3*OB+2*COORD_BITS] == '0) && (out_q[3*OB+6*COORD_BITS-1:3*OB+5*COORD_BITS] == '0) && (out_q[3*OB+9*COORD_BITS-1:3*OB+8*COORD_BITS] == '0), "segment result has a nonzero z field")

endmodule

// ===== dv/tb_triangle_normal_centroid_bbox_unit.sv =====
// Self-checking testbench of the triangle normal, centroid and bounding box unit.
`timescale 1ns / 1ps

module tb_triangle_normal_centroid_bbox_unit;
	import tncb_pkg::*;

	localparam int CB    = 24;
	localparam int NFB   = 14;
	localparam int NB    = NFB + 2;
	localparam int IN_W  = 216;
	localparam int OUT_W = 264;
	// This margin covers the pipeline latency.
	localparam int SETTLE = NFB + 30;
	localparam int CYCLE_LIMIT = 400000;

	// The scoreboard keeps the expected results in arrival order and compares
	// every output transaction with the oldest of them.
	class result_board;
		logic [OUT_W-1:0] pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function void note(logic [OUT_W-1:0] want);
			pending.push_back(want);
		endfunction

		function void check(logic [OUT_W-1:0] got);
			logic [OUT_W-1:0] want;
			string names[12];
			int w, lo;
			names = '{"normal_x", "normal_y", "normal_z", "centroid_x", "centroid_y",
				"centroid_z", "box_min_x", "box_min_y", "box_min_z", "box_max_x",
				"box_max_y", "box_max_z"};
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			for (int f = 0; f < 12; f++) begin
				w  = (f < 3) ? NB : CB;
				lo = (f < 3) ? f * NB : 3 * NB + (f - 3) * CB;
				if (((want ^ got) >> lo) & ((1 << w) - 1)) begin
					$display("%0t: %s expected %h actual %h", $time, names[f],
						(want >> lo) & ((1 << w) - 1), (got >> lo) & ((1 << w) - 1));
					errors++;
				end
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wen = 1'b0;
	logic [1:0]        cfg_wdata = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OUT_W-1:0]  m_axis_tdata;

	result_board board = new();
	logic [1:0] dim_now = DIM_TRIANGLE;   // what the dimensions register holds
	bit calm = 0;                          // no idling on either side while set
	bit hold_start = 0;                    // asks the receiver for a long hold-off
	int hold_left = 0;
	int wait_left = 0;
	int cycles = 0;

	triangle_normal_centroid_bbox_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Rounded mean of two or three coordinates, ties away from zero.
	function automatic longint rounded_mean(longint sum, longint cnt);
		longint mag, q;
		mag = (sum < 0) ? -sum : sum;
		q = (2 * mag + cnt) / (2 * cnt);
		return (sum < 0) ? -q : q;
	endfunction

	// Expected output word for one element under the given dimensions setting.
	function automatic logic [OUT_W-1:0] predict_element(logic [IN_W-1:0] d,
			logic [1:0] dm);
		logic signed [CB-1:0] t;
		longint v[3][3];
		longint a[3], b[3], nc[3], res[3], cen[3], mn[3], mx[3], sum;
		logic [255:0] sq[3], s, rhs, lhs, dd;
		longint lo, hi, mid;
		int nv;
		logic [OUT_W-1:0] r;
		nv = (dm == DIM_SEGMENT) ? 2 : 3;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				t = d[(i * 3 + j) * CB +: CB];
				v[i][j] = t;
			end
		if (nv == 2) begin
			nc[0] = v[1][1] - v[0][1];
			nc[1] = -(v[1][0] - v[0][0]);
			nc[2] = 0;
		end else begin
			for (int j = 0; j < 3; j++) begin
				a[j] = v[1][j] - v[0][j];
				b[j] = v[2][j] - v[0][j];
			end
			nc[0] = a[1] * b[2] - a[2] * b[1];
			nc[1] = a[2] * b[0] - a[0] * b[2];
			nc[2] = a[0] * b[1] - a[1] * b[0];
		end
		for (int i = 0; i < 3; i++) begin
			sq[i] = (nc[i] < 0) ? 256'(-nc[i]) : 256'(nc[i]);
			sq[i] = sq[i] * sq[i];
		end
		s = sq[0] + sq[1] + sq[2];
		// Each component is the largest magnitude q with (2q-1)^2 * |n|^2 no more
		// than n_i^2 * 2^(2F+2), which is the exact round-to-nearest of n_i/|n|.
		for (int i = 0; i < 3; i++) begin
			res[i] = 0;
			if (s != 0) begin
				lo = 0;
				hi = 1 << NFB;
				rhs = sq[i] << (2 * NFB + 2);
				while (lo < hi) begin
					mid = (lo + hi + 1) / 2;
					dd = 256'(2 * mid - 1);
					lhs = dd * dd * s;
					if (lhs <= rhs) lo = mid;
					else hi = mid - 1;
				end
				res[i] = (nc[i] < 0) ? -lo : lo;
			end
		end
		for (int j = 0; j < 3; j++) begin
			cen[j] = 0;
			mn[j] = 0;
			mx[j] = 0;
			if (j < nv) begin
				sum = 0;
				mn[j] = v[0][j];
				mx[j] = v[0][j];
				for (int i = 0; i < nv; i++) begin
					sum += v[i][j];
					if (v[i][j] < mn[j]) mn[j] = v[i][j];
					if (v[i][j] > mx[j]) mx[j] = v[i][j];
				end
				cen[j] = rounded_mean(sum, nv);
			end
		end
		for (int j = 0; j < 3; j++) begin
			r[j * NB +: NB] = res[j][NB-1:0];
			r[3 * NB + j * CB +: CB] = cen[j][CB-1:0];
			r[3 * NB + (3 + j) * CB +: CB] = mn[j][CB-1:0];
			r[3 * NB + (6 + j) * CB +: CB] = mx[j][CB-1:0];
		end
		return r;
	endfunction

	// Receiver: checks each output transaction and, unless calm is set, may idle for a
	// random gap after it, or holds off for a long stretch when asked to.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			board.check(m_axis_tdata);
		if (hold_start) begin
			hold_start = 0;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			wait_left = calm ? 0 : $urandom_range(0, 3);
			m_axis_tready <= (wait_left == 0);
		end else if (wait_left > 0) begin
			wait_left--;
			m_axis_tready <= (wait_left == 0);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Offers one element after a random gap and waits for its transaction. The
	// valid is only lowered when a gap follows, so back-to-back items keep it high.
	task automatic send_element(logic [IN_W-1:0] d);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		do @(posedge clk); while (!s_axis_tready);
		board.note(predict_element(d, dim_now));
	endtask

	// Withdraws the input, lets every expected result arrive, then lets the
	// pipeline settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_dimensions(logic [1:0] value);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		dim_now = value;
		@(posedge clk);
	endtask

	function automatic logic [CB-1:0] pick_coord();
		case ($urandom_range(0, 4))
			0: return CB'($urandom);
			1: return CB'($urandom_range(0, 32) - 16);
			2: begin
				case ($urandom_range(0, 3))
					0: return 24'h7fffff;
					1: return 24'h800000;
					2: return 24'h000000;
					default: return 24'hffffff;
				endcase
			end
			default: return CB'($urandom_range(0, 8191) - 4096);
		endcase
	endfunction

	// Mostly unrelated random vertices; some elements are degenerate on purpose
	// (repeated vertices or collinear points) so the zero normal appears too.
	function automatic logic [IN_W-1:0] random_element();
		logic [IN_W-1:0] d;
		logic [CB-1:0] k;
		for (int f = 0; f < 9; f++) d[f * CB +: CB] = pick_coord();
		case ($urandom_range(0, 9))
			0: d[3 * CB +: 3 * CB] = d[0 +: 3 * CB];
			1: d[6 * CB +: 3 * CB] = d[3 * CB +: 3 * CB];
			2: begin
				k = CB'($urandom_range(0, 7) - 3);
				for (int j = 0; j < 3; j++)
					d[(6 + j) * CB +: CB] = d[j * CB +: CB] +
						k * (d[(3 + j) * CB +: CB] - d[j * CB +: CB]);
			end
			default: ;
		endcase
		return d;
	endfunction

	function automatic logic [IN_W-1:0] pack_element(logic [CB-1:0] ax, ay, az,
			bx, by, bz, cx, cy, cz);
		return {cz, cy, cx, bz, by, bx, az, ay, ax};
	endfunction

	// Directed elements: extremes, zero and axis-aligned normals, degenerate
	// elements and centroid rounding ties of both signs.
	task automatic directed_elements();
		send_element('0);
		send_element({9{24'h7fffff}});
		send_element({9{24'h800000}});
		send_element(pack_element(24'h800000, 24'h800000, 24'h800000,
			24'h7fffff, 24'h800000, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff));
		send_element(pack_element(24'h7fffff, 24'h7fffff, 24'h7fffff,
			24'h800000, 24'h7fffff, 24'h800000, 24'h800000, 24'h800000, 24'h7fffff));
		send_element(pack_element(0, 0, 0, 256, 0, 0, 0, 256, 0));
		send_element(pack_element(0, 0, 0, 0, 256, 0, 0, 0, 256));
		send_element(pack_element(0, 0, 0, 0, 0, 256, 256, 0, 0));
		send_element(pack_element(1, 1, 1, 0, 0, 0, 0, 0, 0));
		send_element(pack_element(1, 1, 1, 1, 1, 1, 0, 0, 0));
		send_element(pack_element(24'hffffff, 24'hffffff, 24'hffffff, 0, 0, 0, 0, 0, 0));
		send_element(pack_element(24'hffffff, 24'hffffff, 24'hffffff,
			24'hffffff, 24'hffffff, 24'hffffff, 0, 0, 0));
		send_element(pack_element(0, 0, 0, 1, 2, 3, 2, 4, 6));
		send_element(pack_element(5, 24'hfffffb, 7, 5, 24'hfffffb, 7, 5, 24'hfffffb, 7));
		send_element(pack_element(0, 0, 0, 3, 4, 0, 24'h7fffff, 24'h800000, 1));
		send_element(pack_element(100, 200, 300, 101, 199, 302, 98, 203, 297));
	endtask

	initial begin
		logic [1:0] settings[6];
		settings = '{DIM_TRIANGLE, DIM_SEGMENT, 2'd0, 2'd1, DIM_SEGMENT, DIM_TRIANGLE};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The register still holds its reset value during the first phase.
		directed_elements();
		drain();
		for (int p = 0; p < 6; p++) begin
			write_dimensions(settings[p]);
			if (p == 1 || p == 3) begin
				directed_elements();
				drain();
			end
			calm = (p == 4);
			if (p == 2) hold_start = 1;
			for (int n = 0; n < 200; n++) begin
				send_element(random_element());
				// The sender waits for every result once, in the middle of the first random phase.
				if (n == 100 && p == 0) drain();
			end
			calm = 0;
			drain();
		end

		if (board.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
